// File: rtl/tdmv_pkg.sv
package tdmv_pkg;

    // fixed point format of every value
    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
    localparam int SHIFT_WIDTH   = PROD_WIDTH - FRACTION_BITS;
    localparam int SUM_WIDTH     = DATA_WIDTH + 2;

    // configuration port
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    // register indexes
    typedef enum logic [0:0] {
        REG_TRANSPOSE  = 1'b0,
        REG_ACCUMULATE = 1'b1
    } cfg_reg_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam prod_t HALF_LSB = prod_t'((PROD_WIDTH'(1) << FRACTION_BITS) >> 1);

    // round a full product to the fraction width, ties up, then saturate
    function automatic data_t fx_round(prod_t p);
        prod_t                         biased;
        logic signed [SHIFT_WIDTH-1:0] shifted;
        data_t                         r;
        biased  = p + HALF_LSB;
        shifted = SHIFT_WIDTH'(biased >>> FRACTION_BITS);
        if (shifted > SHIFT_WIDTH'(DATA_MAX))
            r = DATA_MAX;
        else if (shifted < SHIFT_WIDTH'(DATA_MIN))
            r = DATA_MIN;
        else
            r = shifted[DATA_WIDTH-1:0];
        return r;
    endfunction

    // saturate a widened sum back to the data range
    function automatic data_t sat_sum(sum_t s);
        data_t r;
        if (s > SUM_WIDTH'(DATA_MAX))
            r = DATA_MAX;
        else if (s < SUM_WIDTH'(DATA_MIN))
            r = DATA_MIN;
        else
            r = s[DATA_WIDTH-1:0];
        return r;
    endfunction

endpackage

// File: rtl/tdmv_in_if.sv
interface tdmv_in_if;
    import tdmv_pkg::*;

    logic  valid;
    logic  ready;
    data_t sub_coef;
    data_t diag_coef;
    data_t super_coef;
    data_t x_value;
    data_t prior_value;
    logic  last_row;

    modport source (
        output valid, sub_coef, diag_coef, super_coef, x_value, prior_value, last_row,
        input  ready
    );

    modport sink (
        input  valid, sub_coef, diag_coef, super_coef, x_value, prior_value, last_row,
        output ready
    );
endinterface

// File: rtl/tdmv_out_if.sv
interface tdmv_out_if;
    import tdmv_pkg::*;

    logic  valid;
    logic  ready;
    data_t row_value;
    logic  last_result;

    modport source (
        output valid, row_value, last_result,
        input  ready
    );

    modport sink (
        input  valid, row_value, last_result,
        output ready
    );
endinterface

// File: rtl/tridiagonal_matrix_vector_product.sv
// channel   dir  handshake       payload
// in_ch     in   valid / ready   sub_coef, diag_coef, super_coef, x_value, prior_value, last_row
// out_ch    out  valid / ready   row_value, last_result
// apb       in   psel / penable  paddr, pwdata, prdata (transpose_mode, accumulate_mode)
//
// one row transaction is taken per cycle while in_ch.ready is high; a result passes the
// operand, product and sum registers after the row that releases it is taken
// a last row releases up to two results (one if no row is held), which share the single output register in turn
// rows that release no result never enter the pipeline
// rst_n clears the held-row flags, the mode registers and all stage valids; no clearing pass
// an output stall backs up through the three stages and then drops in_ch.ready
module tridiagonal_matrix_vector_product (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tdmv_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [tdmv_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [tdmv_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                             pready,
    tdmv_in_if.sink                          in_ch,
    tdmv_out_if.source                       out_ch
);
    import tdmv_pkg::*;

    // configuration registers
    logic     transpose_reg;
    logic     accumulate_reg;
    logic     cfg_write;
    cfg_reg_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose_reg  <= 1'b0;
            accumulate_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_TRANSPOSE:  transpose_reg  <= pwdata[0];
                REG_ACCUMULATE: accumulate_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_sel)
            REG_TRANSPOSE:  prdata[0] = transpose_reg;
            REG_ACCUMULATE: prdata[0] = accumulate_reg;
            default: prdata = '0;
        endcase
    end

    // held rows
    data_t older_x_reg, held_x_reg, held_sub_reg, held_diag_reg;
    data_t held_super_reg, older_super_reg, held_prior_reg;
    logic  row_pending_reg, first_row_held_reg;

    // pipeline control
    logic in_fire, out_fire, s1_load;
    logic s1_free, s2_free, s3_free;
    logic s1_valid_reg, s2_valid_reg;

    // stage 1: operands of the two possible results
    logic  s1_r0v_reg, s1_r1v_reg;
    data_t pc0_reg, px0_reg, dc0_reg, dx0_reg, nc0_reg, nx0_reg, prior0_reg;
    data_t pc1_reg, px1_reg, dc1_reg, dx1_reg, prior1_reg;
    data_t pc0_next, pc1_next, nc0_next;

    // stage 2: products
    logic  s2_r0v_reg, s2_r1v_reg;
    prod_t m0a_reg, m0b_reg, m0c_reg, m1a_reg, m1b_reg;
    data_t p0_reg, p1_reg;

    // stage 3: output register
    logic  o_v0_reg, o_v1_reg;
    data_t val0_reg, val1_reg;
    data_t val0_next, val1_next;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign s1_load  = in_fire && (row_pending_reg || in_ch.last_row);

    assign s3_free  = !(o_v0_reg || o_v1_reg) || (out_fire && !(o_v0_reg && o_v1_reg));
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ch.ready = s1_free;

    // held row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg        <= '0;
            held_x_reg         <= '0;
            held_sub_reg       <= '0;
            held_diag_reg      <= '0;
            held_super_reg     <= '0;
            older_super_reg    <= '0;
            held_prior_reg     <= '0;
            row_pending_reg    <= 1'b0;
            first_row_held_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            if (in_ch.last_row)
            begin
                row_pending_reg    <= 1'b0;
                first_row_held_reg <= 1'b1;
            end
            else
            begin
                first_row_held_reg <= !row_pending_reg;
                older_x_reg        <= held_x_reg;
                older_super_reg    <= held_super_reg;
                held_x_reg         <= in_ch.x_value;
                held_sub_reg       <= in_ch.sub_coef;
                held_diag_reg      <= in_ch.diag_coef;
                held_super_reg     <= in_ch.super_coef;
                held_prior_reg     <= in_ch.prior_value;
                row_pending_reg    <= 1'b1;
            end
        end
    end

    // neighbor coefficient selection by mode
    always_comb
    begin
        pc0_next = '0;
        if (!first_row_held_reg)
            pc0_next = transpose_reg ? older_super_reg : held_sub_reg;
        nc0_next = transpose_reg ? in_ch.sub_coef : held_super_reg;
        pc1_next = '0;
        if (row_pending_reg)
            pc1_next = transpose_reg ? held_super_reg : in_ch.sub_coef;
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_v0_reg     <= 1'b0;
            o_v1_reg     <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s1_load;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
            begin
                o_v0_reg <= s2_valid_reg && s2_r0v_reg;
                o_v1_reg <= s2_valid_reg && s2_r1v_reg;
            end
            else if (out_fire)
                o_v0_reg <= 1'b0;
        end
    end

    // operand register
    always_ff @(posedge clk)
    begin
        if (s1_free && s1_load)
        begin
            s1_r0v_reg <= row_pending_reg;
            s1_r1v_reg <= in_ch.last_row;
            pc0_reg    <= pc0_next;
            px0_reg    <= older_x_reg;
            dc0_reg    <= held_diag_reg;
            dx0_reg    <= held_x_reg;
            nc0_reg    <= nc0_next;
            nx0_reg    <= in_ch.x_value;
            prior0_reg <= accumulate_reg ? held_prior_reg : '0;
            pc1_reg    <= pc1_next;
            px1_reg    <= held_x_reg;
            dc1_reg    <= in_ch.diag_coef;
            dx1_reg    <= in_ch.x_value;
            prior1_reg <= accumulate_reg ? in_ch.prior_value : '0;
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_r0v_reg <= s1_r0v_reg;
            s2_r1v_reg <= s1_r1v_reg;
            m0a_reg    <= prod_t'(pc0_reg) * prod_t'(px0_reg);
            m0b_reg    <= prod_t'(dc0_reg) * prod_t'(dx0_reg);
            m0c_reg    <= prod_t'(nc0_reg) * prod_t'(nx0_reg);
            m1a_reg    <= prod_t'(pc1_reg) * prod_t'(px1_reg);
            m1b_reg    <= prod_t'(dc1_reg) * prod_t'(dx1_reg);
            p0_reg     <= prior0_reg;
            p1_reg     <= prior1_reg;
        end
    end

    // round each product, sum and saturate
    always_comb
    begin
        val0_next = sat_sum(SUM_WIDTH'(fx_round(m0a_reg)) + SUM_WIDTH'(fx_round(m0b_reg))
                          + SUM_WIDTH'(fx_round(m0c_reg)) + SUM_WIDTH'(p0_reg));
        val1_next = sat_sum(SUM_WIDTH'(fx_round(m1a_reg)) + SUM_WIDTH'(fx_round(m1b_reg))
                          + SUM_WIDTH'(p1_reg));
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            val0_reg <= val0_next;
            val1_reg <= val1_next;
        end
    end

    // the neighbor result goes first, the last-row result last
    assign out_ch.valid       = o_v0_reg || o_v1_reg;
    assign out_ch.row_value   = o_v0_reg ? val0_reg : val1_reg;
    assign out_ch.last_result = !o_v0_reg;

    // an operand set always carries at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_r0v_reg || s1_r1v_reg))
        else $error("operand stage holds no result");

    // a last row leaves nothing held
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.last_row) |=> (!row_pending_reg && first_row_held_reg))
        else $error("row still held after last row");

    // input stalls only when every stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && s2_valid_reg && (o_v0_reg || o_v1_reg)))
        else $error("input stalled with a free stage");

    // the second result of a pair follows the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && o_v0_reg && o_v1_reg) |=> (!o_v0_reg && o_v1_reg))
        else $error("last-row result lost after neighbor result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import tdmv_pkg::*;

    localparam int    RANDOM_ROWS   = 1900;
    localparam int    PHASE_ROWS    = 150;
    localparam int    SETTLE_CYCLES = 6;
    localparam int    GAP_MAX       = 6;
    localparam int    STALL_MAX     = 12;
    localparam int    N_DIRECTED    = 22;
    localparam data_t ONE           = 32'sh0001_0000;

    // one matrix row as it goes into the block
    typedef struct {
        data_t sub;
        data_t diag;
        data_t sup;
        data_t x;
        data_t prior;
        logic  last;
    } row_t;

    // one result element as it leaves the block
    typedef struct {
        data_t row_value;
        logic  last_result;
    } row_out_t;

    // directed stimulus: optional mode write, the row, optional typed-in result
    typedef struct {
        bit    cfg;
        bit    tr;
        bit    acc;
        data_t sub;
        data_t diag;
        data_t sup;
        data_t x;
        data_t prior;
        bit    last;
        bit    typed;
        data_t want;
    } step_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic pready;

    tdmv_in_if  in_ch ();
    tdmv_out_if out_ch ();

    tridiagonal_matrix_vector_product dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // product state: the held row and the one before it, plus the mode copy
    data_t x_before;
    data_t sup_before;
    data_t x_kept;
    data_t sub_kept;
    data_t diag_kept;
    data_t sup_kept;
    data_t prior_kept;
    bit    have_row     = 1'b0;
    bit    kept_is_first = 1'b1;
    bit    mode_transpose = 1'b0;
    bit    mode_accum     = 1'b0;

    row_out_t due_values[$];
    row_out_t head_value;

    int mismatches     = 0;
    int values_checked = 0;
    int rows_sent      = 0;
    int vectors_sent   = 0;
    int mode_writes    = 0;
    int midway_changes = 0;
    int burst_left     = 0;
    int gap_max        = GAP_MAX;

    step_t directed_steps[N_DIRECTED];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #(400000 * 12);
        $display("tridiagonal_matrix_vector_product: mismatch");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic data_t clamp_wide(logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = DATA_MAX;
        lo = DATA_MIN;
        if (v > hi)
            return DATA_MAX;
        else if (v < lo)
            return DATA_MIN;
        return data_t'(v);
    endfunction

    // fixed point product: exact, round half up, saturate
    function automatic data_t q_mul(data_t a, data_t b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] p;
        wa = a;
        wb = b;
        p  = wa * wb + (64'sd1 <<< (FRACTION_BITS - 1));
        p  = p >>> FRACTION_BITS;
        return clamp_wide(p);
    endfunction

    // one result element: three rounded products, optional prior, one saturation
    function automatic data_t row_sum(data_t pc, data_t px, data_t dc, data_t dx,
                                      data_t nc, data_t nx, data_t prior);
        logic signed [63:0] t0;
        logic signed [63:0] t1;
        logic signed [63:0] t2;
        logic signed [63:0] tp;
        t0 = q_mul(pc, px);
        t1 = q_mul(dc, dx);
        t2 = q_mul(nc, nx);
        tp = prior;
        if (!mode_accum)
            tp = '0;
        return clamp_wide(t0 + t1 + t2 + tp);
    endfunction

    // advance the product by one accepted row and queue the elements it releases
    function automatic void advance_product(row_t r);
        data_t    pc;
        data_t    px;
        data_t    nc;
        row_out_t res;
        if (have_row)
        begin
            pc = kept_is_first ? data_t'(0) : (mode_transpose ? sup_before : sub_kept);
            nc = mode_transpose ? r.sub : sup_kept;
            res.row_value   = row_sum(pc, x_before, diag_kept, x_kept, nc, r.x, prior_kept);
            res.last_result = 1'b0;
            due_values.push_back(res);
        end
        if (r.last)
        begin
            pc = '0;
            px = '0;
            if (have_row)
            begin
                pc = mode_transpose ? sup_kept : r.sub;
                px = x_kept;
            end
            res.row_value   = row_sum(pc, px, r.diag, r.x, '0, '0, r.prior);
            res.last_result = 1'b1;
            due_values.push_back(res);
            have_row      = 1'b0;
            kept_is_first = 1'b1;
        end
        else
        begin
            kept_is_first = !have_row;
            x_before   = x_kept;
            sup_before = sup_kept;
            x_kept     = r.x;
            sub_kept   = r.sub;
            diag_kept  = r.diag;
            sup_kept   = r.sup;
            prior_kept = r.prior;
            have_row   = 1'b1;
        end
    endfunction

    // random field value: extremes, full range or small magnitudes
    function automatic data_t pick_value();
        int unsigned v;
        case ($urandom_range(0, 9))
            0: return DATA_MIN;
            1: return DATA_MAX;
            2, 3, 4: return data_t'($urandom);
            default:
            begin
                v = $urandom_range(0, 2097151);
                return data_t'(v) - data_t'(1048576);
            end
        endcase
    endfunction

    // register write: setup then access cycle
    task automatic apb_write(cfg_reg_t idx, bit value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_TRANSPOSE:  mode_transpose = value;
            REG_ACCUMULATE: mode_accum     = value;
            default: ;
        endcase
        mode_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register read back, mode bit compared
    task automatic check_mode_reg(cfg_reg_t idx, bit want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[0] !== want)
            flag_mismatch(idx == REG_TRANSPOSE ? "transpose_mode read" : "accumulate_mode read",
                          prdata, {31'b0, want});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop sending and wait for every pending result to drain
    task automatic quiesce();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (due_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_modes(bit tr, bit acc);
        quiesce();
        apb_write(REG_TRANSPOSE, tr);
        apb_write(REG_ACCUMULATE, acc);
        check_mode_reg(REG_TRANSPOSE, tr);
        check_mode_reg(REG_ACCUMULATE, acc);
    endtask

    // send one row transaction, with bursts and gaps
    task automatic send_row(row_t r, bit typed, data_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.sub_coef    <= r.sub;
        in_ch.diag_coef   <= r.diag;
        in_ch.super_coef  <= r.sup;
        in_ch.x_value     <= r.x;
        in_ch.prior_value <= r.prior;
        in_ch.last_row    <= r.last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        rows_sent++;
        if (r.last)
            vectors_sent++;
        advance_product(r);
        if (typed)
            due_values[due_values.size() - 1].row_value = want;
    endtask

    // result receiver: random stalls, with the stall percentage redrawn from a set of four
    initial
    begin
        int stall_left;
        int stall_pct;
        int cyc;
        stall_left = 0;
        stall_pct  = 0;
        cyc        = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cyc % 256 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 40;
                    default: stall_pct = 75;
                endcase
            end
            cyc++;
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, STALL_MAX);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (due_values.size() == 0)
                flag_mismatch("result with none expected", out_ch.row_value, '0);
            else
            begin
                head_value = due_values.pop_front();
                values_checked++;
                if (out_ch.row_value !== head_value.row_value)
                    flag_mismatch("row_value", out_ch.row_value, head_value.row_value);
                if (out_ch.last_result !== head_value.last_result)
                    flag_mismatch("last_result", {31'b0, out_ch.last_result},
                                  {31'b0, head_value.last_result});
            end
        end
    end

    // main sequence
    initial
    begin : main_seq
        row_t r;
        int   k;
        int   len;
        int   phase;
        int   rnd_rows;
        int   next_phase_at;
        bit   twist;
        logic [1:0] modes;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.sub_coef    = '0;
        in_ch.diag_coef   = '0;
        in_ch.super_coef  = '0;
        in_ch.x_value     = '0;
        in_ch.prior_value = '0;
        in_ch.last_row    = 1'b0;

        // single rows with results read off directly, then full vectors, then one more single row
        directed_steps = '{
            '{1'b1, 1'b0, 1'b0, '0, ONE, '0, 32'sh0002_0000, DATA_MAX, 1'b1,
              1'b1, 32'sh0002_0000},
            '{1'b0, 1'b0, 1'b0, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN, '0, 1'b1,
              1'b1, DATA_MAX},
            '{1'b0, 1'b0, 1'b0, '0, DATA_MAX, '0, DATA_MIN, '0, 1'b1, 1'b1, DATA_MIN},
            '{1'b0, 1'b0, 1'b0, '0, 32'sh0000_0001, '0, 32'sh0000_8000, '0, 1'b1,
              1'b1, 32'sh0000_0001},
            '{1'b0, 1'b0, 1'b0, '0, 32'shFFFF_FFFF, '0, 32'sh0000_8000, '0, 1'b1,
              1'b1, '0},
            '{1'b1, 1'b0, 1'b1, '0, '0, '0, DATA_MAX, DATA_MAX, 1'b1, 1'b1, DATA_MAX},
            '{1'b0, 1'b0, 1'b0, '0, DATA_MAX, '0, DATA_MAX, DATA_MAX, 1'b1,
              1'b1, DATA_MAX},
            '{1'b0, 1'b0, 1'b0, '0, DATA_MIN, '0, DATA_MAX, DATA_MIN, 1'b1,
              1'b1, DATA_MIN},
            '{1'b0, 1'b0, 1'b0, '0, ONE, '0, 32'sh0003_0000, 32'shFFFF_0000, 1'b1,
              1'b1, 32'sh0002_0000},
            '{1'b1, 1'b0, 1'b0, DATA_MIN, 32'sh0002_0000, 32'sh0000_8000,
              32'sh0001_8000, '0, 1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, 32'shFFFF_0000, ONE, DATA_MAX, 32'sh0003_0000, '0,
              1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, 32'sh7FFF_0000, 32'sh0000_0001, 32'shFFFE_0000,
              DATA_MAX, '0, 1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, ONE, DATA_MIN, DATA_MAX, 32'sh0000_4000, DATA_MAX,
              1'b1, 1'b0, '0},
            '{1'b1, 1'b1, 1'b0, DATA_MAX, ONE, 32'sh0002_0000, 32'shFFFF_8000, '0,
              1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, 32'shFFFD_0000, DATA_MAX, 32'sh0000_0003,
              32'sh0000_FFFF, DATA_MIN, 1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, DATA_MIN, 32'shFFFF_FFFF, DATA_MIN, DATA_MIN, '0,
              1'b1, 1'b0, '0},
            '{1'b1, 1'b1, 1'b1, ONE, ONE, 32'sh0000_8000, 32'sh0005_0000, ONE,
              1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, 32'sh0000_8000, 32'shFFFF_0000, DATA_MAX,
              32'sh0000_0003, DATA_MAX, 1'b1, 1'b0, '0},
            '{1'b1, 1'b0, 1'b1, 32'sh1234_5678, 32'shEDCB_A988, 32'sh0F0F_0F0F,
              32'shF0F0_F0F1, 32'sh5555_5555, 1'b0, 1'b0, '0},
            '{1'b1, 1'b1, 1'b0, 32'shAAAA_AAAA, 32'sh0000_FFFF, 32'sh7654_3210,
              32'sh0001_0001, 32'shCCCC_CCCC, 1'b0, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, 32'shFEDC_BA98, ONE, 32'sh3333_3333, 32'shFFFF_FFFF,
              32'sh0000_0001, 1'b1, 1'b0, '0},
            '{1'b0, 1'b0, 1'b0, '0, 32'shFFFF_0000, '0, DATA_MIN, '0, 1'b1,
              1'b1, DATA_MAX}
        };

        // reset
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        for (k = 0; k < N_DIRECTED; k++)
        begin
            if (directed_steps[k].cfg)
            begin
                set_modes(directed_steps[k].tr, directed_steps[k].acc);
                if (have_row)
                    midway_changes++;
            end
            r.sub   = directed_steps[k].sub;
            r.diag  = directed_steps[k].diag;
            r.sup   = directed_steps[k].sup;
            r.x     = directed_steps[k].x;
            r.prior = directed_steps[k].prior;
            r.last  = directed_steps[k].last;
            send_row(r, directed_steps[k].typed, directed_steps[k].want);
        end

        // random vectors, mostly short, with mode phases
        phase         = 0;
        rnd_rows      = 0;
        next_phase_at = 0;
        while (rnd_rows < RANDOM_ROWS)
        begin
            if (rnd_rows >= next_phase_at)
            begin
                modes = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
                set_modes(modes[1], modes[0]);
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
                phase++;
                next_phase_at += PHASE_ROWS;
            end
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            twist = (len > 1) && ($urandom_range(0, 7) == 0);
            for (k = 0; k < len; k++)
            begin
                r.sub   = pick_value();
                r.diag  = pick_value();
                r.sup   = pick_value();
                r.x     = pick_value();
                r.prior = pick_value();
                r.last  = (k == len - 1);
                send_row(r, 1'b0, '0);
                // mode change while a row is held
                if (k == 0 && twist)
                begin
                    set_modes(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                    midway_changes++;
                end
            end
            rnd_rows += len;
        end

        // drain
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (due_values.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d rows in %0d vectors, checked %0d result elements",
                 rows_sent, vectors_sent, values_checked);
        $display("%0d mode register writes, %0d mode changes with a row held",
                 mode_writes, midway_changes);
        if (mismatches == 0)
            $display("tridiagonal_matrix_vector_product: match");
        else
            $display("tridiagonal_matrix_vector_product: mismatch");
        $finish;
    end

endmodule
